// File: design/hdt_pkg.sv
// Shared types, constants and helpers for the HID descriptor item tokenizer.
`timescale 1ns / 1ps
package hdt_pkg;

  localparam logic [1:0] SIZE_MASK      = 2'b11;
  localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
  localparam logic [7:0] USAGE_PAGE_TAG = 8'h04;
  localparam logic [31:0] MONITOR_PAGE  = 32'h0000_0080;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       desc_last;
  } hdt_in_t;

  typedef struct packed {
    logic [7:0]  item_tag;
    logic [1:0]  item_kind;
    logic [2:0]  byte_count;
    logic [31:0] item_value;
    logic        truncated;
    logic        monitor_decided;
    logic        monitor_match;
    logic        desc_end;
  } hdt_out_t;

  // Number of data bytes announced by a prefix; size code three means four bytes.
  function automatic logic [2:0] size_of_prefix(input logic [7:0] prefix);
    logic [2:0] n;
    begin
      case (prefix[1:0])
        SIZE_CODE_FOUR: n = 3'd4;
        default:        n = {1'b0, prefix[1:0]};
      endcase
      return n;
    end
  endfunction

endpackage

// File: design/hdt_core.sv
// Parse state and token decode for one descriptor byte per transfer.
`timescale 1ns / 1ps
module hdt_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  hdt_pkg::hdt_in_t item,
  output logic            tok_valid,
  output hdt_pkg::hdt_out_t tok
);
  import hdt_pkg::*;

  logic [2:0]  rem_r, rem_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        seen_r, seen_nxt;
  logic        flag_r, flag_nxt;

  logic [7:0]  prefix_v;
  logic [31:0] acc_v;
  logic [2:0]  n_v;
  logic        emit_v;
  logic        trunc_v;
  logic        seen_v;
  logic        flag_v;
  logic [7:0]  tag_v;

  always_comb begin
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    prefix_nxt = prefix_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    flag_nxt   = flag_r;
    prefix_v   = prefix_r;
    acc_v      = acc_r;
    n_v        = size_of_prefix(item.desc_byte);
    emit_v     = 1'b0;
    trunc_v    = 1'b0;
    if (take) begin
      if (rem_r == 3'd0) begin
        prefix_v = item.desc_byte;
        acc_v    = '0;
        pos_nxt  = '0;
        if (n_v == 3'd0) begin
          emit_v = 1'b1;
        end else begin
          rem_nxt = n_v;
          if (item.desc_last) begin
            emit_v  = 1'b1;
            trunc_v = 1'b1;
          end
        end
      end else begin
        acc_v   = acc_r | ({24'd0, item.desc_byte} << {pos_r, 3'b000});
        pos_nxt = pos_r + 2'd1;
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          emit_v = 1'b1;
        end else if (item.desc_last) begin
          emit_v  = 1'b1;
          trunc_v = 1'b1;
        end
      end
      prefix_nxt = prefix_v;
      acc_nxt    = acc_v;
    end

    tag_v  = {prefix_v[7:2], 2'b00};
    seen_v = seen_r;
    flag_v = flag_r;
    // Only the first Usage Page of a descriptor decides the monitor flag.
    if (tag_v == USAGE_PAGE_TAG && !seen_r) begin
      seen_v = 1'b1;
      flag_v = (acc_v == MONITOR_PAGE);
    end

    tok.item_tag        = tag_v;
    tok.item_kind       = prefix_v[3:2];
    tok.byte_count      = size_of_prefix(prefix_v);
    tok.item_value      = acc_v;
    tok.truncated       = trunc_v;
    tok.monitor_decided = seen_v;
    tok.monitor_match   = flag_v;
    tok.desc_end        = item.desc_last;
    tok_valid           = emit_v;

    if (emit_v) begin
      if (item.desc_last) begin
        rem_nxt    = '0;
        pos_nxt    = '0;
        prefix_nxt = '0;
        acc_nxt    = '0;
        seen_nxt   = 1'b0;
        flag_nxt   = 1'b0;
      end else begin
        rem_nxt  = '0;
        pos_nxt  = '0;
        seen_nxt = seen_v;
        flag_nxt = flag_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      pos_r    <= '0;
      prefix_r <= '0;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      flag_r   <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      prefix_r <= prefix_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      flag_r   <= flag_nxt;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("bytes remaining out of range");

  a_pos_rem_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rem_r} + {2'b00, pos_r}) <= 4'd4)
    else $error("byte position and remaining count disagree");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.desc_last) |=> (rem_r == 3'd0 && !seen_r && !flag_r))
    else $error("state not cleared after descriptor end");

  a_flag_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |-> seen_r)
    else $error("monitor flag set without a Usage Page");

endmodule

// File: design/hdt_out_reg.sv
// Result register that holds a token until the downstream side takes it.
`timescale 1ns / 1ps
module hdt_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hdt_pkg::hdt_out_t load_data,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output hdt_pkg::hdt_out_t out_data
);
  import hdt_pkg::*;

  logic     valid_r, valid_nxt;
  hdt_out_t data_r, data_nxt;

  // The register can take a new token when it is empty or its token leaves now.
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (free) begin
      valid_nxt = load;
      if (load) begin
        data_nxt = load_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (valid_r && data_r == $past(data_r)))
    else $error("held token overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (free && load) |=> (valid_r && data_r == $past(load_data)))
    else $error("loaded token not presented");

  a_monitor_decided: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(data_r.monitor_match && !data_r.monitor_decided))
    else $error("monitor verdict before the first Usage Page");

endmodule

// File: design/hid_descriptor_item_tokenizer.sv
// Top level of the HID report descriptor short-item tokenizer.
`timescale 1ns / 1ps
// Takes a report descriptor one byte per transfer and delivers one token per
// short item: tag, type, data size, little-endian data, a truncated flag, the
// monitor verdict of the first Usage Page and a descriptor-end mark. Every byte
// is accepted into an input register and decoded from it into a result
// register once that register is free, so one byte is taken per cycle while
// out_stall is low; the sustained rate is one byte per cycle and is set only
// by the result register draining. in_stall rises only while both the input
// and result registers are full and out_stall is high.
module hid_descriptor_item_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hdt_pkg::hdt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hdt_pkg::hdt_out_t out_data
);
  import hdt_pkg::*;

  logic     stage_valid_r, stage_valid_nxt;
  hdt_in_t  stage_data_r, stage_data_nxt;
  logic     advance;
  logic     take;
  logic     tok_valid;
  hdt_out_t tok;

  // The staged byte is decoded when the result register can take its token.
  assign take     = stage_valid_r && advance;
  assign in_stall = stage_valid_r && !advance;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_data_nxt  = stage_data_r;
    if (!in_stall) begin
      stage_valid_nxt = in_valid;
      if (in_valid) begin
        stage_data_nxt = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
    stage_data_r <= stage_data_nxt;
  end

  hdt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (stage_data_r),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  hdt_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (tok_valid),
    .load_data (tok),
    .free      (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !advance) |=> (stage_valid_r && stage_data_r == $past(stage_data_r)))
    else $error("staged byte lost while the result side is blocked");

  a_token_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    tok_valid |-> take)
    else $error("token produced without a decoded byte");

  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (take && stage_data_r.desc_last) |-> tok_valid)
    else $error("descriptor end produced no token");

endmodule

// File: tb/sv/hdt_token_checker.sv
// Checker for the HID descriptor item tokenizer: predicts tokens and compares them.
`timescale 1ns / 1ps
module hdt_token_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  hdt_pkg::hdt_in_t in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  hdt_pkg::hdt_out_t out_data,
  output int               fail_count,
  output int               pending
);
  import hdt_pkg::*;

  hdt_out_t expected_tokens[$];

  // Tokenizer state as the block should hold it.
  logic [2:0]  data_left;
  logic [2:0]  data_pos;
  logic [7:0]  item_prefix;
  logic [31:0] data_word;
  logic        usage_page_seen;
  logic        monitor_seen;

  function automatic logic [2:0] data_len(input logic [1:0] code);
    return (code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, code};
  endfunction

  task automatic clear_tokenizer();
    data_left = '0;
    data_pos = '0;
    item_prefix = '0;
    data_word = '0;
    usage_page_seen = 1'b0;
    monitor_seen = 1'b0;
  endtask

  task automatic close_item(input logic cut_short, input logic closes_desc);
    hdt_out_t tok;
    logic [7:0] tag;
    tag = item_prefix & ~{6'd0, SIZE_MASK};
    // Only the first Usage Page of a descriptor settles the monitor verdict.
    if (tag == USAGE_PAGE_TAG && !usage_page_seen) begin
      usage_page_seen = 1'b1;
      monitor_seen = (data_word == MONITOR_PAGE);
    end
    tok.item_tag = tag;
    tok.item_kind = item_prefix[3:2];
    tok.byte_count = data_len(item_prefix[1:0]);
    tok.item_value = data_word;
    tok.truncated = cut_short;
    tok.monitor_decided = usage_page_seen;
    tok.monitor_match = monitor_seen;
    tok.desc_end = closes_desc;
    expected_tokens.push_back(tok);
    if (closes_desc) begin
      clear_tokenizer();
    end else begin
      data_left = '0;
      data_pos = '0;
    end
  endtask

  task automatic take_desc_byte(input hdt_in_t x);
    if (data_left == 0) begin
      item_prefix = x.desc_byte;
      data_word = '0;
      data_pos = '0;
      if (data_len(x.desc_byte[1:0]) == 0) begin
        close_item(1'b0, x.desc_last);
      end else begin
        data_left = data_len(x.desc_byte[1:0]);
        if (x.desc_last) close_item(1'b1, 1'b1);
      end
    end else begin
      data_word = data_word | ({24'd0, x.desc_byte} << {data_pos[1:0], 3'b000});
      data_pos = data_pos + 3'd1;
      data_left = data_left - 3'd1;
      if (data_left == 0) begin
        close_item(1'b0, x.desc_last);
      end else if (x.desc_last) begin
        close_item(1'b1, 1'b1);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token(input hdt_out_t got);
    hdt_out_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: token with none expected, actual %0h", $time, got);
      fail_count++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("item_tag", want.item_tag, got.item_tag);
      check_field("item_kind", want.item_kind, got.item_kind);
      check_field("byte_count", want.byte_count, got.byte_count);
      check_field("item_value", want.item_value, got.item_value);
      check_field("truncated", want.truncated, got.truncated);
      check_field("monitor_decided", want.monitor_decided, got.monitor_decided);
      check_field("monitor_match", want.monitor_match, got.monitor_match);
      check_field("desc_end", want.desc_end, got.desc_end);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tokenizer();
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) check_token(out_data);
      if (in_valid && !in_stall) take_desc_byte(in_data);
    end
    pending = expected_tokens.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the HID descriptor item tokenizer: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import hdt_pkg::*;

  localparam int TARGET_BYTES = 1400;
  localparam int QUIET_AFTER = 1150;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hdt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  hdt_out_t out_data;
  int       fail_count;
  int       pending;

  int bytes_sent = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  always #10 clk = ~clk;

  hid_descriptor_item_tokenizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  hdt_token_checker token_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Offer one byte and hold it until the transfer completes.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (!quiet && !hold_off && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {b, is_last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    quiet = (bytes_sent >= QUIET_AFTER);
  endtask

  task automatic send_descriptor();
    logic [7:0] stream[$];
    logic [7:0] prefix;
    int n_items, len, last_start, keep;
    bit page_item, monitor_data;
    n_items = $urandom_range(1, 10);
    last_start = 0;
    for (int k = 0; k < n_items; k++) begin
      page_item = ($urandom_range(0, 3) == 0);
      monitor_data = ($urandom_range(0, 1) == 1);
      prefix = page_item ? {USAGE_PAGE_TAG[7:2], 2'($urandom_range(0, 3))} : 8'($urandom);
      last_start = stream.size();
      stream.push_back(prefix);
      len = (prefix[1:0] == SIZE_CODE_FOUR) ? 4 : prefix[1:0];
      for (int j = 0; j < len; j++) begin
        if (page_item && monitor_data) stream.push_back((j == 0) ? 8'h80 : 8'h00);
        else stream.push_back(8'($urandom));
      end
    end
    // Now and then the descriptor stops partway through its final item.
    if ($urandom_range(0, 4) == 0 && stream.size() - 1 > last_start) begin
      keep = $urandom_range(last_start + 1, stream.size() - 1);
      while (stream.size() > keep) void'(stream.pop_back());
    end
    foreach (stream[i]) send_byte(stream[i], i == stream.size() - 1);
  endtask

  // Unstructured bytes; the final one closes the descriptor so the next starts aligned.
  task automatic send_noise();
    int len;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom), (i == len - 1) || ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin : receiver
    int cycles;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    repeat (200) @(posedge clk);
    // One long hold so both pipeline registers fill and the input backs up.
    hold_off = 1'b1;
    out_stall <= 1'b1;
    repeat (60) @(posedge clk);
    out_stall <= 1'b0;
    hold_off = 1'b0;
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        cycles = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      cycles = $urandom_range(1, 15);
      repeat (cycles) @(posedge clk);
    end
  end

  initial begin : stimulus
    int waited;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First Usage Page with the monitor page, then a later one that must not override it.
    send_byte(8'h05, 0); send_byte(8'h80, 0);
    send_byte(8'h06, 0); send_byte(8'h01, 0); send_byte(8'h00, 0);
    // Item without data, then a four-byte reserved item with every bit set.
    send_byte(8'h00, 0);
    send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0);
    send_byte(8'hFF, 0); send_byte(8'hFF, 0);
    send_byte(8'h09, 0); send_byte(8'h00, 0);
    send_byte(8'hC0, 1);
    // A truncated first Usage Page still decides the verdict from its partial data.
    send_byte(8'h07, 0); send_byte(8'h80, 1);
    send_byte(8'h04, 1);
    send_byte(8'h17, 1);
    send_byte(8'h06, 0); send_byte(8'h12, 0); send_byte(8'h34, 1);

    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_descriptor();
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
